// ===== design/assert_macros.svh =====
// Assertion macros used by the checker file.
// Each macro expects signals named clk and rst in the calling scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define A_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset
`define A_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== design/lcache_pkg.sv =====
// Package for the LFU cache with lifetimes: types, codes and defaults.
// Used by the interfaces, controller, datapath and top level.
`default_nettype none
package lcache_pkg;

  localparam int CAPACITY_DEF   = 64;
  localparam int KEY_BITS_DEF   = 32;
  localparam int VALUE_BITS_DEF = 64;
  localparam int ACTION_W       = 3;
  localparam int TTL_W          = 32;
  localparam int OCC_OUT_W      = 7;
  localparam int CFG_W          = 7;
  localparam int CNT_W          = 32;
  localparam int STAMP_W        = 32;
  localparam int SEC_W          = 32;
  localparam logic [CFG_W-1:0] CAP_RESET = 7'd64;

  typedef enum logic [ACTION_W-1:0] {
    ACT_GET    = 3'd0,
    ACT_PUT    = 3'd1,
    ACT_REMOVE = 3'd2,
    ACT_PROBE  = 3'd3,
    ACT_TICK   = 3'd4,
    ACT_CLEAR  = 3'd5
  } action_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_APPLY,
    ST_RESULT
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic scan;
    logic apply;
    logic out_load;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic scan_last;
  } status_t;

endpackage
`default_nettype wire

// ===== design/lcache_if.sv =====
// Channel interfaces: request, response and configuration write.
// Depends on lcache_pkg for default widths.
`default_nettype none
interface lcache_req_if #(
  parameter int KEY_W   = lcache_pkg::KEY_BITS_DEF,
  parameter int VALUE_W = lcache_pkg::VALUE_BITS_DEF
);
  logic                           valid;
  logic                           ready;
  logic [lcache_pkg::ACTION_W-1:0] action;
  logic [KEY_W-1:0]               key;
  logic [VALUE_W-1:0]             value;
  logic [lcache_pkg::TTL_W-1:0]   ttl;
  modport source (output valid, action, key, value, ttl, input ready);
  modport sink   (input valid, action, key, value, ttl, output ready);
endinterface

interface lcache_rsp_if #(
  parameter int KEY_W   = lcache_pkg::KEY_BITS_DEF,
  parameter int VALUE_W = lcache_pkg::VALUE_BITS_DEF
);
  logic                             valid;
  logic                             ready;
  logic                             hit;
  logic [VALUE_W-1:0]               read_value;
  logic [lcache_pkg::OCC_OUT_W-1:0] occupancy;
  logic                             evicted;
  logic [KEY_W-1:0]                 evicted_key;
  logic [lcache_pkg::OCC_OUT_W-1:0] expired_count;
  modport source (output valid, hit, read_value, occupancy, evicted, evicted_key,
                  expired_count, input ready);
  modport sink   (input valid, hit, read_value, occupancy, evicted, evicted_key,
                  expired_count, output ready);
endinterface

interface lcache_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [lcache_pkg::CFG_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

// ===== design/lcache_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module lcache_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

// ===== design/lcache_ctrl.sv =====
// Controller FSM: sequences load, entry scan, apply and result hand-off.
// Depends on lcache_pkg.
`default_nettype none
module lcache_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                req_valid,
  output      logic                req_ready,
  output      logic                rsp_valid,
  input  wire logic                rsp_ready,
  output      lcache_pkg::cmd_t    cmd,
  input  wire lcache_pkg::status_t status
);
  import lcache_pkg::*;

  state_t state, state_next;
  logic   out_free;

  assign out_free = !rsp_valid || rsp_ready;

  // State register and output-valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (req_valid) state_next = ST_SCAN;
      ST_SCAN:   if (status.scan_last) state_next = ST_DRAIN;
      ST_DRAIN:  state_next = ST_APPLY;
      ST_APPLY:  state_next = ST_RESULT;
      ST_RESULT: if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd       = '0;
    req_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        cmd.load  = req_valid;
      end
      ST_SCAN:   cmd.scan = 1'b1;
      ST_DRAIN:  ;
      ST_APPLY:  cmd.apply = 1'b1;
      ST_RESULT: cmd.out_load = out_free;
      default:   ;
    endcase
  end
endmodule
`default_nettype wire

// ===== design/lcache_dp.sv =====
// Datapath: entry RAM, valid bits, scan trackers, apply logic, result registers.
// Depends on lcache_pkg and lcache_ram.
`default_nettype none
module lcache_dp #(
  parameter int CAPACITY   = lcache_pkg::CAPACITY_DEF,
  parameter int KEY_BITS   = lcache_pkg::KEY_BITS_DEF,
  parameter int VALUE_BITS = lcache_pkg::VALUE_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire lcache_pkg::cmd_t                 cmd,
  output      lcache_pkg::status_t              status,
  input  wire logic                             cfg_we,
  input  wire logic [lcache_pkg::CFG_W-1:0]     cfg_data,
  input  wire logic [lcache_pkg::ACTION_W-1:0]  in_action,
  input  wire logic [KEY_BITS-1:0]              in_key,
  input  wire logic [VALUE_BITS-1:0]            in_value,
  input  wire logic [lcache_pkg::TTL_W-1:0]     in_ttl,
  output      logic                             out_hit,
  output      logic [VALUE_BITS-1:0]            out_read_value,
  output      logic [lcache_pkg::OCC_OUT_W-1:0] out_occupancy,
  output      logic                             out_evicted,
  output      logic [KEY_BITS-1:0]              out_evicted_key,
  output      logic [lcache_pkg::OCC_OUT_W-1:0] out_expired_count
);
  import lcache_pkg::*;

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int OCC_W = $clog2(CAPACITY + 1);
  localparam int EXP_W = SEC_W + 1;
  // Record layout, LSB first: no_expiry, expiry, stamp, count, data, key
  localparam int O_EXP = 1;
  localparam int O_STP = O_EXP + EXP_W;
  localparam int O_CNT = O_STP + STAMP_W;
  localparam int O_DAT = O_CNT + CNT_W;
  localparam int O_KEY = O_DAT + VALUE_BITS;
  localparam int REC_W = O_KEY + KEY_BITS;

  // Operation and global state
  logic [ACTION_W-1:0]   op_action;
  logic [KEY_BITS-1:0]   op_key;
  logic [VALUE_BITS-1:0] op_value;
  logic [TTL_W-1:0]      op_ttl;
  logic [SEC_W-1:0]      seconds_now;
  logic [STAMP_W-1:0]    stamp_ctr;
  logic [OCC_W-1:0]      valid_total;
  logic [CFG_W-1:0]      cap_reg;
  logic [CAPACITY-1:0]   valid;

  // Scan pipeline
  logic [IDX_W-1:0] raddr;
  logic             rd_vld;
  logic [IDX_W-1:0] rd_idx;
  logic             rd_bit;
  logic [REC_W-1:0] rdata;

  // Scan trackers
  logic                  m_found;
  logic [IDX_W-1:0]      m_idx;
  logic [VALUE_BITS-1:0] m_data;
  logic [CNT_W-1:0]      m_cnt;
  logic                  f_found;
  logic [IDX_W-1:0]      f_idx;
  logic                  v_found;
  logic [IDX_W-1:0]      v_idx;
  logic [CNT_W-1:0]      v_cnt;
  logic [STAMP_W-1:0]    v_age;
  logic [KEY_BITS-1:0]   v_key;
  logic [OCC_W-1:0]      exp_cnt;

  // Result registers
  logic                  r_hit;
  logic [VALUE_BITS-1:0] r_rd;
  logic                  r_ev;
  logic [KEY_BITS-1:0]   r_evk;

  // Fields of the record being scanned
  logic [KEY_BITS-1:0] s_key;
  logic [CNT_W-1:0]    s_cnt;
  logic [STAMP_W-1:0]  s_age;
  logic [EXP_W-1:0]    s_exp;
  logic                s_noexp;
  logic                s_expire;
  logic                s_better;

  assign s_key    = rdata[O_KEY +: KEY_BITS];
  assign s_cnt    = rdata[O_CNT +: CNT_W];
  assign s_age    = stamp_ctr - rdata[O_STP +: STAMP_W];
  assign s_exp    = rdata[O_EXP +: EXP_W];
  assign s_noexp  = rdata[0];
  assign s_expire = (op_action == ACT_TICK) && rd_bit && !s_noexp &&
                    (s_exp <= {1'b0, seconds_now});
  assign s_better = !v_found || (s_cnt < v_cnt) || ((s_cnt == v_cnt) && (s_age > v_age));

  assign status.scan_last = (raddr == IDX_W'(CAPACITY - 1));

  // Apply-phase values
  logic [OCC_W-1:0]   cap_eff;
  logic [CNT_W-1:0]   cnt_up;
  logic [EXP_W-1:0]   deadline;
  logic               evict;
  logic [IDX_W-1:0]   slot;
  logic               ins;
  logic               ram_we;
  logic [IDX_W-1:0]   waddr;
  logic [REC_W-1:0]   wdata;
  // Deadline of the matched entry, kept for a get refresh
  logic [EXP_W:0]     rdata_keep_exp;
  logic [EXP_W:0]     m_exp;

  assign rdata_keep_exp = m_exp;

  always_comb begin
    if (cap_reg == '0) begin
      cap_eff = OCC_W'(1);
    end else if (32'(cap_reg) > CAPACITY) begin
      cap_eff = OCC_W'(CAPACITY);
    end else begin
      cap_eff = OCC_W'(cap_reg);
    end
  end

  assign cnt_up   = (m_cnt == '1) ? m_cnt : m_cnt + CNT_W'(1);
  assign deadline = {1'b0, seconds_now} + {1'b0, op_ttl};
  assign evict    = (op_action == ACT_PUT) && !m_found && (valid_total >= cap_eff) && v_found;
  assign slot     = (evict && !(f_found && (f_idx < v_idx))) ? v_idx : f_idx;
  assign ins      = (op_action == ACT_PUT) && !m_found && (evict || f_found);

  // RAM write on apply: refresh on get/put hit, new entry on put miss
  always_comb begin
    ram_we = 1'b0;
    waddr  = m_idx;
    wdata  = {op_key, op_value, cnt_up, stamp_ctr, deadline, (op_ttl == '0)};
    if (cmd.apply) begin
      case (op_action)
        ACT_GET: begin
          ram_we = m_found;
          wdata  = {op_key, m_data, cnt_up, stamp_ctr, rdata_keep_exp};
        end
        ACT_PUT: begin
          ram_we = m_found || ins;
          if (!m_found) begin
            waddr = slot;
            wdata = {op_key, op_value, CNT_W'(1), stamp_ctr, deadline, (op_ttl == '0)};
          end
        end
        default: ram_we = 1'b0;
      endcase
    end
  end

  lcache_ram #(
    .WIDTH(REC_W),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (cmd.scan),
    .raddr(raddr),
    .rdata(rdata)
  );

  // Control and global state
  always_ff @(posedge clk) begin
    if (rst) begin
      seconds_now <= '0;
      stamp_ctr   <= '0;
      valid_total <= '0;
      cap_reg     <= CAP_RESET;
      valid       <= '0;
      rd_vld      <= 1'b0;
      raddr       <= '0;
    end else begin
      if (cfg_we) begin
        cap_reg <= cfg_data;
      end
      rd_vld <= cmd.scan;
      if (cmd.load) begin
        raddr <= '0;
        if (in_action == ACT_TICK && seconds_now != '1) begin
          seconds_now <= seconds_now + SEC_W'(1);
        end
      end else if (cmd.scan) begin
        raddr <= raddr + IDX_W'(1);
      end
      // Expiry during the scan
      if (rd_vld && s_expire) begin
        valid[rd_idx] <= 1'b0;
        valid_total   <= valid_total - OCC_W'(1);
      end
      if (cmd.apply) begin
        case (op_action)
          ACT_GET: begin
            if (m_found) stamp_ctr <= stamp_ctr + STAMP_W'(1);
          end
          ACT_PUT: begin
            if (m_found || ins) stamp_ctr <= stamp_ctr + STAMP_W'(1);
            if (evict) valid[v_idx] <= 1'b0;
            if (ins) valid[slot] <= 1'b1;
            if (ins && !evict) valid_total <= valid_total + OCC_W'(1);
          end
          ACT_REMOVE: begin
            if (m_found) begin
              valid[m_idx] <= 1'b0;
              valid_total  <= valid_total - OCC_W'(1);
            end
          end
          ACT_CLEAR: begin
            valid       <= '0;
            valid_total <= '0;
          end
          default: ;
        endcase
      end
    end
  end

  // Operation capture, scan trackers and results
  always_ff @(posedge clk) begin
    if (cmd.scan) begin
      rd_idx <= raddr;
      rd_bit <= valid[raddr];
    end
    if (cmd.load) begin
      op_action <= in_action;
      op_key    <= in_key;
      op_value  <= in_value;
      op_ttl    <= in_ttl;
      m_found   <= 1'b0;
      f_found   <= 1'b0;
      v_found   <= 1'b0;
      exp_cnt   <= '0;
    end else if (rd_vld) begin
      if (rd_bit && s_key == op_key && !m_found) begin
        m_found <= 1'b1;
        m_idx   <= rd_idx;
        m_data  <= rdata[O_DAT +: VALUE_BITS];
        m_cnt   <= s_cnt;
        m_exp   <= rdata[O_STP-1:0];
      end
      if (!rd_bit && !f_found) begin
        f_found <= 1'b1;
        f_idx   <= rd_idx;
      end
      if (rd_bit && s_better) begin
        v_found <= 1'b1;
        v_idx   <= rd_idx;
        v_cnt   <= s_cnt;
        v_age   <= s_age;
        v_key   <= s_key;
      end
      if (s_expire) begin
        exp_cnt <= exp_cnt + OCC_W'(1);
      end
    end
    if (cmd.apply) begin
      r_hit <= m_found && (op_action == ACT_GET || op_action == ACT_PUT ||
                           op_action == ACT_REMOVE || op_action == ACT_PROBE);
      r_rd  <= (m_found && op_action == ACT_GET) ? m_data : '0;
      r_ev  <= evict;
      r_evk <= evict ? v_key : '0;
      if (op_action != ACT_TICK) exp_cnt <= '0;
    end
    if (cmd.out_load) begin
      out_hit           <= r_hit;
      out_read_value    <= r_rd;
      out_occupancy     <= OCC_OUT_W'(valid_total);
      out_evicted       <= r_ev;
      out_evicted_key   <= r_evk;
      out_expired_count <= OCC_OUT_W'(exp_cnt);
    end
  end
endmodule
`default_nettype wire

// ===== design/lfu_cache_with_ttl_unit.sv =====
// Top level of the LFU cache with lifetimes: controller plus datapath.
// Depends on lcache_pkg, lcache_if, lcache_ctrl, lcache_dp, lcache_ram.
//
//   channel  role    payload
//   cfg      sink    data: capacity register
//   req      sink    action, key, value, ttl
//   rsp      source  hit, read_value, occupancy, evicted, evicted_key, expired_count
//
// Every request is handled in turn: one RAM read per entry slot for the key match,
// free-slot and victim search, then drain, apply and the output load.
// One request is in work at a time; the next is accepted once the result is
// parked in the output register, even if rsp is stalled.
// Reset (rst, synchronous) empties the store and sets capacity to 64.
// cfg is always ready.
`default_nettype none
module lfu_cache_with_ttl_unit #(
  parameter int CAPACITY   = lcache_pkg::CAPACITY_DEF,
  parameter int KEY_BITS   = lcache_pkg::KEY_BITS_DEF,
  parameter int VALUE_BITS = lcache_pkg::VALUE_BITS_DEF
) (
  input wire logic     clk,
  input wire logic     rst,
  lcache_cfg_if.sink   cfg,
  lcache_req_if.sink   req,
  lcache_rsp_if.source rsp
);
  import lcache_pkg::*;

  cmd_t    cmd;
  status_t status;

  assign cfg.ready = 1'b1;

  lcache_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req.valid),
    .req_ready(req.ready),
    .rsp_valid(rsp.valid),
    .rsp_ready(rsp.ready),
    .cmd      (cmd),
    .status   (status)
  );

  lcache_dp #(
    .CAPACITY  (CAPACITY),
    .KEY_BITS  (KEY_BITS),
    .VALUE_BITS(VALUE_BITS)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .status           (status),
    .cfg_we           (cfg.valid),
    .cfg_data         (cfg.data),
    .in_action        (req.action),
    .in_key           (req.key),
    .in_value         (req.value),
    .in_ttl           (req.ttl),
    .out_hit          (rsp.hit),
    .out_read_value   (rsp.read_value),
    .out_occupancy    (rsp.occupancy),
    .out_evicted      (rsp.evicted),
    .out_evicted_key  (rsp.evicted_key),
    .out_expired_count(rsp.expired_count)
  );
endmodule
`default_nettype wire

// ===== design/lcache_chk.sv =====
// Port-level checker for the LFU cache top level, bound in below.
// Depends on assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module lcache_chk (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       req_valid,
  input wire logic       req_ready,
  input wire logic       rsp_valid,
  input wire logic       rsp_ready,
  input wire logic       rsp_hit,
  input wire logic       rsp_evicted,
  input wire logic [6:0] rsp_expired_count
);
  // Busy right after taking a request
  `A_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready)
  // Eviction only on a put of a new key
  `A_IMPL(a_evict_on_miss, rsp_valid && rsp_evicted, !rsp_hit)
  // Expiry count only on a tick, which neither hits nor evicts
  `A_IMPL(a_expiry_alone, rsp_valid && (rsp_expired_count != 7'd0), !rsp_hit && !rsp_evicted)
  // Stalled response stays
  `A_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)
endmodule

bind lfu_cache_with_ttl_unit lcache_chk u_lcache_chk (
  .clk              (clk),
  .rst              (rst),
  .req_valid        (req.valid),
  .req_ready        (req.ready),
  .rsp_valid        (rsp.valid),
  .rsp_ready        (rsp.ready),
  .rsp_hit          (rsp.hit),
  .rsp_evicted      (rsp.evicted),
  .rsp_expired_count(rsp.expired_count)
);
`default_nettype wire
